// ===== hdl/gb7_pkg.sv =====
// ----------------------------------------------------------------------------
// gb7_pkg
// Shared types, constants and helpers of the 7x7 blur unit.
// ----------------------------------------------------------------------------
package gb7_pkg;

  localparam int unsigned MAX_SIDE  = 1024;
  localparam int unsigned KRAD      = 3;
  localparam int unsigned KDIM      = 2 * KRAD + 1;
  localparam int unsigned LB_ROWS   = KDIM - 1;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int unsigned COL_W     = $clog2(MAX_SIDE);
  localparam int unsigned ROW_W     = SIDE_W + 1;
  localparam int unsigned DELAY_W   = $clog2(3 * MAX_SIDE + 4);
  localparam int unsigned POS_W     = $clog2(MAX_SIDE * MAX_SIDE + 3 * MAX_SIDE + 4);
  localparam int unsigned LB_W      = LB_ROWS * SAMPLE_W;

  localparam int unsigned WGT_W     = 7;
  localparam int unsigned ROW_SUM_W = SAMPLE_W + 9;
  localparam int unsigned SUM_W     = SAMPLE_W + 11;

  localparam int unsigned DIVISOR     = 700;
  localparam int unsigned CLAMP_MAX   = 60000;
  localparam int unsigned CLAMP_SUM   = CLAMP_MAX * DIVISOR;
  localparam int unsigned DIV_IN_W    = $clog2(CLAMP_SUM);
  localparam int unsigned RECIP_SHIFT = 32;
  localparam longint unsigned RECIP   = (64'd1 << RECIP_SHIFT) / DIVISOR;
  localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
  localparam int unsigned PROD_W      = DIV_IN_W + RECIP_W;
  localparam int unsigned REM_W       = $clog2(2 * DIVISOR);

  localparam int unsigned CFG_RST     = 1024;

  localparam logic [WGT_W-1:0] WEIGHT [KDIM][KDIM] = '{
    '{7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0},
    '{7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0},
    '{7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0},
    '{7'd5, 7'd32, 7'd100, 7'd100, 7'd100, 7'd32, 7'd5},
    '{7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0},
    '{7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0},
    '{7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0}
  };

  typedef logic [SAMPLE_W-1:0] sample_t;
  // Element k holds the sample k rows above the newest one in that column.
  typedef sample_t [KDIM-1:0] col_vec_t;
  // Index 0 is the oldest column of the window.
  typedef col_vec_t [KDIM-1:0] window_t;

  typedef struct packed {
    logic            vld;
    logic            last;
    logic [KDIM-1:0] row_ok;
    logic [KDIM-1:0] col_ok;
  } gb7_ctl_t;

  // Clip the programmed side into the supported range.
  function automatic logic [SIDE_W-1:0] eff_side(logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > MAX_SIDE) begin
      w = MAX_SIDE;
    end
    return SIDE_W'(w);
  endfunction

  function automatic logic [DELAY_W-1:0] fill_delay(logic [SIDE_W-1:0] side);
    return DELAY_W'(32'(side) * 3 + 3);
  endfunction

endpackage

// ===== hdl/gb7_conv.sv =====
// ----------------------------------------------------------------------------
// gb7_conv
// Weighted window sum, clamp and divide by 700, ending in the output register.
// ----------------------------------------------------------------------------
module gb7_conv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  gb7_pkg::gb7_ctl_t           ctl_i,
  input  gb7_pkg::window_t            win_i,
  output logic                        out_vld_o,
  output logic [gb7_pkg::SAMPLE_W-1:0] value_o,
  output logic                        last_o
);
  import gb7_pkg::*;

  logic [ROW_SUM_W-1:0] rs_d [KDIM];
  logic [ROW_SUM_W-1:0] rs_q [KDIM];
  logic                 c_vld_q, c_last_q;
  logic [KDIM-1:0]      c_row_ok_q;

  logic [SUM_W-1:0]     sum_d, sum_q;
  logic                 d_vld_q, d_last_q;

  logic                 e_vld_q, e_last_q, e_clamp_q;
  logic [DIV_IN_W-1:0]  e_x_q;
  logic [PROD_W-1:0]    e_prod_q;

  logic                 f_vld_q, f_last_q, f_clamp_q;
  logic [DIV_IN_W-1:0]  f_x_q, f_m700_q;
  logic [SAMPLE_W-1:0]  f_q0_q;
  logic [SAMPLE_W-1:0]  q0_d;

  logic [DIV_IN_W-1:0]  rem_full;
  logic [REM_W-1:0]     rem;
  logic [SAMPLE_W-1:0]  value_d;

  logic                 out_vld_q, out_last_q;
  logic [SAMPLE_W-1:0]  out_value_q;

  // Per-row weighted sums; taps left or right of the frame drop out.
  always_comb begin
    for (int j = 0; j < KDIM; j++) begin
      rs_d[j] = '0;
      for (int i = 0; i < KDIM; i++) begin
        if (ctl_i.col_ok[i]) begin
          rs_d[j] = rs_d[j] + ROW_SUM_W'(WEIGHT[j][i]) * ROW_SUM_W'(win_i[i][KDIM-1-j]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < KDIM; j++) begin
      if (c_row_ok_q[j]) begin
        sum_d = sum_d + SUM_W'(rs_q[j]);
      end
    end
  end

  assign q0_d     = SAMPLE_W'(e_prod_q >> RECIP_SHIFT);
  assign rem_full = f_x_q - f_m700_q;
  assign rem      = REM_W'(rem_full);

  // The reciprocal estimate is low by at most one; fix it with the remainder.
  always_comb begin
    if (f_clamp_q) begin
      value_d = SAMPLE_W'(CLAMP_MAX);
    end else if (rem >= REM_W'(DIVISOR)) begin
      value_d = f_q0_q + SAMPLE_W'(1);
    end else begin
      value_d = f_q0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q   <= ctl_i.vld;
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      f_vld_q   <= e_vld_q;
      out_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q        <= rs_d;
      c_last_q    <= ctl_i.last;
      c_row_ok_q  <= ctl_i.row_ok;
      sum_q       <= sum_d;
      d_last_q    <= c_last_q;
      e_last_q    <= d_last_q;
      e_clamp_q   <= (sum_q >= SUM_W'(CLAMP_SUM));
      e_x_q       <= DIV_IN_W'(sum_q);
      e_prod_q    <= PROD_W'(DIV_IN_W'(sum_q)) * PROD_W'(RECIP);
      f_last_q    <= e_last_q;
      f_clamp_q   <= e_clamp_q;
      f_x_q       <= e_x_q;
      f_q0_q      <= q0_d;
      f_m700_q    <= DIV_IN_W'(DIV_IN_W'(q0_d) * DIV_IN_W'(DIVISOR));
      out_last_q  <= f_last_q;
      out_value_q <= value_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign value_o   = out_value_q;
  assign last_o    = out_last_q;

endmodule

// ===== hdl/gaussian_blur_7x7_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_7x7_unit
// Streaming 7x7 blur of a square 16-bit heightmap with line-buffer memory.
// ----------------------------------------------------------------------------
// Samples arrive on the in channel (valid/ready) in raster order; results
// leave on the out channel (valid/ready), one per pixel, in raster order.
// cfg_we_i/cfg_data_i program the frame side (0 acts as 1, larger than 1024
// acts as 1024) and restart at the first pixel; write it only while idle.
// After a frame, send 3*side+3 flush beats to drain the remaining results.
// Padding beats inside the frame are taken and dropped.
// Throughput: one beat per cycle unless the receiver stalls. The line
// buffer is a single 1024 x 96 memory with one read and one write per
// cycle; a read that hits the column written in the same cycle takes
// forwarded data. The result for a pixel leaves the output register after
// the beat 3*side+3 positions later is accepted (the memory read shares the
// accept edge, then 1 window update and 5 arithmetic stages including the
// output register).
// When the receiver stalls, the output register holds and the whole pipe
// freezes; in_ready_o drops only while a result waits untaken.
// Reset empties the pipe, restores side 1024 and restarts the frame; the
// line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_blur_7x7_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gb7_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gb7_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         is_padding_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gb7_pkg::SAMPLE_W-1:0] filtered_value_o,
  output logic                         end_of_frame_o
);
  import gb7_pkg::*;

  localparam int unsigned MW = SIDE_W + 1;

  logic                en;
  logic                accept, enter, in_frame, emit, qlast;
  logic                col_end, qcol_end;
  logic [SIDE_W-1:0]   side_m1;

  logic [SIDE_W-1:0]   side_d, side_q;
  logic [DELAY_W-1:0]  delay_d, delay_q;
  logic [ROW_W-1:0]    row_d, row_q;
  logic [COL_W-1:0]    col_d, col_q;
  logic [POS_W-1:0]    pos_d, pos_q;
  logic [COL_W-1:0]    qrow_d, qrow_q;
  logic [COL_W-1:0]    qcol_d, qcol_q;

  logic                s1_vld_q, s1_emit_q, s1_last_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [COL_W-1:0]    s1_col_q, s1_qrow_q, s1_qcol_q;

  logic [LB_W-1:0]     lbuf_mem [MAX_SIDE];
  logic [LB_W-1:0]     lb_rdata_q, fwd_data_q, col_word, lb_wdata;
  logic                fwd_q, lb_we;

  col_vec_t            new_col;
  window_t             win_q;
  gb7_ctl_t            s2_ctl_d, s2_ctl_q;

  logic                conv_vld;

  assign en         = !conv_vld || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign in_frame   = row_q < ROW_W'(side_q);
  assign enter      = accept && !(in_frame && is_padding_i);
  assign emit       = pos_q >= POS_W'(delay_q);
  assign side_m1    = side_q - SIDE_W'(1);
  assign col_end    = SIDE_W'(col_q) == side_m1;
  assign qcol_end   = SIDE_W'(qcol_q) == side_m1;
  assign qlast      = emit && qcol_end && (SIDE_W'(qrow_q) == side_m1);

  // Position of the next beat and of the pixel whose window it completes.
  always_comb begin
    side_d  = side_q;
    delay_d = delay_q;
    row_d   = row_q;
    col_d   = col_q;
    pos_d   = pos_q;
    qrow_d  = qrow_q;
    qcol_d  = qcol_q;
    if (cfg_we_i) begin
      side_d  = eff_side(cfg_data_i);
      delay_d = fill_delay(eff_side(cfg_data_i));
      row_d   = '0;
      col_d   = '0;
      pos_d   = '0;
      qrow_d  = '0;
      qcol_d  = '0;
    end else if (enter) begin
      if (qlast) begin
        row_d  = '0;
        col_d  = '0;
        pos_d  = '0;
        qrow_d = '0;
        qcol_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
        if (col_end) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (emit) begin
          if (qcol_end) begin
            qcol_d = '0;
            qrow_d = qrow_q + COL_W'(1);
          end else begin
            qcol_d = qcol_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= eff_side(CFG_W'(CFG_RST));
      delay_q  <= fill_delay(eff_side(CFG_W'(CFG_RST)));
      row_q    <= '0;
      col_q    <= '0;
      pos_q    <= '0;
      qrow_q   <= '0;
      qcol_q   <= '0;
      s1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      s2_ctl_q <= '0;
    end else begin
      side_q  <= side_d;
      delay_q <= delay_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pos_q   <= pos_d;
      qrow_q  <= qrow_d;
      qcol_q  <= qcol_d;
      if (en) begin
        s1_vld_q <= enter;
        s2_ctl_q <= s2_ctl_d;
      end
      if (enter) begin
        fwd_q <= lb_we && (s1_col_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sample_q <= in_frame ? sample_i : '0;
      s1_col_q    <= col_q;
      s1_emit_q   <= emit;
      s1_last_q   <= qlast;
      s1_qrow_q   <= qrow_q;
      s1_qcol_q   <= qcol_q;
    end
    if (enter) begin
      fwd_data_q <= lb_wdata;
    end
  end

  // Line buffer: one word per column, the six rows above the current one.
  assign lb_we    = s1_vld_q && en;
  assign col_word = fwd_q ? fwd_data_q : lb_rdata_q;
  assign lb_wdata = {col_word[LB_W-SAMPLE_W-1:0], s1_sample_q};

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lbuf_mem[s1_col_q] <= lb_wdata;
    end
    if (enter) begin
      lb_rdata_q <= lbuf_mem[col_q];
    end
  end

  always_comb begin
    new_col[0] = s1_sample_q;
    for (int k = 1; k < KDIM; k++) begin
      new_col[k] = col_word[(k-1)*SAMPLE_W +: SAMPLE_W];
    end
  end

  // Advance the window by one column per beat.
  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      for (int i = 0; i < KDIM - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[KDIM-1] <= new_col;
    end
  end

  // Edge masks: a tap counts only when its row and column lie in the frame.
  always_comb begin
    s2_ctl_d.vld  = s1_vld_q && s1_emit_q;
    s2_ctl_d.last = s1_last_q;
    for (int i = 0; i < KDIM; i++) begin
      s2_ctl_d.col_ok[i] = (MW'(s1_qcol_q) + MW'(i) >= MW'(KRAD)) &&
                           (MW'(s1_qcol_q) + MW'(i) < MW'(side_q) + MW'(KRAD));
      s2_ctl_d.row_ok[i] = (MW'(s1_qrow_q) + MW'(i) >= MW'(KRAD)) &&
                           (MW'(s1_qrow_q) + MW'(i) < MW'(side_q) + MW'(KRAD));
    end
  end

  gb7_conv u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (s2_ctl_q),
    .win_i     (win_q),
    .out_vld_o (conv_vld),
    .value_o   (filtered_value_o),
    .last_o    (end_of_frame_o)
  );

  assign out_valid_o = conv_vld;

endmodule

// ===== hdl/gb7_checker.sv =====
// ----------------------------------------------------------------------------
// gb7_checker
// Port-level checks of the blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module gb7_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gb7_pkg::SAMPLE_W-1:0] filtered_value_o,
  input logic                         end_of_frame_o
);
  import gb7_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(filtered_value_o) && $stable(end_of_frame_o))
    else $error("stalled result changed");

  // Input backpressure comes only from a waiting result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with no result waiting");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> filtered_value_o <= SAMPLE_W'(CLAMP_MAX))
    else $error("result above clamp limit");

  // The pipe freezes as a whole: a stalled output leaves nothing to take in.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind gaussian_blur_7x7_unit gb7_checker u_gb7_checker (.*);

// ===== tb/sv/gaussian_blur_7x7_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_7x7_unit_tb
// Self-checking bench for the streaming 7x7 heightmap blur.
// ----------------------------------------------------------------------------
// Frames of random side and content are streamed through the unit. Padding
// noise goes inside frames and mixed flush beats go after them. Each
// accepted beat updates a local blur tracker, which queues the expected
// pixel. Each pixel taken from the output is checked against the oldest
// queued one. Both sides stall at random. The side register is reprogrammed
// only after the pipe has drained.
// ----------------------------------------------------------------------------
module gaussian_blur_7x7_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_CAP   = 1024;
  localparam int unsigned HIST_LEN   = 6 * SIDE_CAP + 8;
  localparam int unsigned BLUR_DIV   = 700;
  localparam int unsigned BLUR_CEIL  = 60000;
  localparam int unsigned RAND_ITEMS = 550;
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned LIMIT      = 200000;

  localparam int unsigned BLUR_KERNEL [7][7] = '{
    '{0,  0,   0,   5,   0,  0, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0, 18,  64, 100,  64, 18, 0},
    '{5, 32, 100, 100, 100, 32, 5},
    '{0, 18,  64, 100,  64, 18, 0},
    '{0,  5,  18,  32,  18,  5, 0},
    '{0,  0,   0,   5,   0,  0, 0}
  };

  typedef struct packed {
    logic [gb7_pkg::SAMPLE_W-1:0] smp;
    logic                         pad;
    logic                         hold;
  } beat_t;

  typedef struct packed {
    logic [gb7_pkg::SAMPLE_W-1:0] value;
    logic                         eof;
  } blur_px_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [gb7_pkg::CFG_W-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [gb7_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                         is_padding_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [gb7_pkg::SAMPLE_W-1:0] filtered_value_o;
  logic                         end_of_frame_o;

  gaussian_blur_7x7_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .is_padding_i     (is_padding_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .end_of_frame_o   (end_of_frame_o)
  );

  // Blur tracker state
  bit [gb7_pkg::SAMPLE_W-1:0] hist [HIST_LEN];
  logic [gb7_pkg::CFG_W-1:0]  side_reg = 11'd1024;
  int unsigned                frame_pos = 0;

  beat_t    beat_q [$];
  blur_px_t blur_due [$];

  int unsigned n_bad = 0;
  int unsigned n_sent = 0;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic int unsigned side_in_use(logic [gb7_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end else if (v > SIDE_CAP) begin
      return SIDE_CAP;
    end
    return v;
  endfunction

  function automatic logic [gb7_pkg::SAMPLE_W-1:0] blur_at(int unsigned side,
                                                            int unsigned oy,
                                                            int unsigned ox);
    int ty;
    int tx;
    longint unsigned acc;
    acc = 0;
    for (int j = 0; j < 7; j++) begin
      for (int i = 0; i < 7; i++) begin
        ty = int'(oy) + j - 3;
        tx = int'(ox) + i - 3;
        // taps off the frame count as zero
        if (ty >= 0 && tx >= 0 && ty < int'(side) && tx < int'(side)) begin
          acc += BLUR_KERNEL[j][i] *
                 hist[(unsigned'(ty) * side + unsigned'(tx)) % HIST_LEN];
        end
      end
    end
    acc = acc / BLUR_DIV;
    if (acc > BLUR_CEIL) begin
      acc = BLUR_CEIL;
    end
    return acc[gb7_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic void track_beat(logic [gb7_pkg::SAMPLE_W-1:0] smp, logic pad);
    int unsigned side;
    int unsigned pixels;
    int unsigned delay;
    int unsigned q;
    blur_px_t px;
    side   = side_in_use(side_reg);
    pixels = side * side;
    delay  = 3 * side + 3;
    if (frame_pos < pixels) begin
      // drop padding that shows up inside the frame
      if (pad) begin
        return;
      end
      hist[frame_pos % HIST_LEN] = smp;
    end
    if (frame_pos >= delay && frame_pos - delay < pixels) begin
      q        = frame_pos - delay;
      px.value = blur_at(side, q / side, q % side);
      px.eof   = (q == pixels - 1);
      blur_due.push_back(px);
      if (px.eof) begin
        frame_pos = 0;
        return;
      end
    end
    frame_pos++;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: one beat at a time from beat_q, random gap after each beat.
  always @(posedge clk_i) begin
    logic  v;
    beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      v = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        track_beat(sample_i, is_padding_i);
        v = 1'b0;
        if ($urandom_range(0, 31) == 0) begin
          in_calm = !in_calm;
        end
        in_gap = in_calm ? 0 : $urandom_range(0, 3);
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (beat_q.size() != 0 && !(beat_q[0].hold && blur_due.size() != 0)) begin
          b = beat_q.pop_front();
          sample_i     <= b.smp;
          is_padding_i <= b.pad;
          v = 1'b1;
        end
      end
      in_valid_i <= v;
    end
  end

  // Receiver: check each pixel taken, then stall for a random count.
  always @(posedge clk_i) begin
    logic     r;
    blur_px_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (blur_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("unexpected pixel: value %0d eof %0b", filtered_value_o,
                     end_of_frame_o);
          end
        end else begin
          want = blur_due.pop_front();
          if (filtered_value_o !== want.value || end_of_frame_o !== want.eof) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("pixel mismatch: value exp %0d got %0d, eof exp %0b got %0b",
                       want.value, filtered_value_o, want.eof, end_of_frame_o);
            end
          end
        end
        if ($urandom_range(0, 31) == 0) begin
          out_calm = !out_calm;
        end
        out_wait = out_calm ? 0 : $urandom_range(0, 3);
      end
      if (out_wait > 0) begin
        r = 1'b0;
        out_wait--;
      end else begin
        r = 1'b1;
      end
      out_ready_i <= r;
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("gaussian_blur_7x7_unit verification failed");
    $finish;
  end

  task automatic push_beat(logic [gb7_pkg::SAMPLE_W-1:0] smp, logic pad,
                           logic hold = 1'b0);
    beat_t b;
    b.smp  = smp;
    b.pad  = pad;
    b.hold = hold;
    beat_q.push_back(b);
  endtask

  // Wait for every beat and pixel, then let beats with no pixel leave the pipe.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (beat_q.size() != 0 || in_valid_i || blur_due.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_side(logic [gb7_pkg::CFG_W-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    side_reg  = v;
    frame_pos = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_frame(int unsigned side, int unsigned cut);
    int unsigned pixels;
    int unsigned style;
    logic [gb7_pkg::SAMPLE_W-1:0] s;
    pixels = side * side;
    style  = $urandom_range(0, 3);
    for (int unsigned k = 0; k < cut; k++) begin
      if (k < pixels) begin
        if ($urandom_range(0, 15) == 0) begin
          push_beat(16'($urandom), 1'b1);
        end
        case (style)
          0: s = 16'($urandom);
          1: s = 16'($urandom_range(60000, 65535));
          2: s = 16'($urandom_range(0, 255));
          default: s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        push_beat(s, 1'b0, $urandom_range(0, 99) == 0);
      end else begin
        // flush beats carry either padding flag
        push_beat(16'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 99) == 0);
      end
      n_sent++;
    end
  endtask

  initial begin
    logic [gb7_pkg::CFG_W-1:0] cfg;
    int unsigned side;
    int unsigned full;
    int unsigned cut;
    int unsigned r;
    bit          cut_open;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset side 1024: partial frame, no pixel due
    push_beat(16'h0000, 1'b0);
    push_beat(16'hFFFF, 1'b1);
    push_beat(16'hFFFF, 1'b0);

    // side above range acts as 1024; restart the frame mid-way
    set_side(11'h7FF);
    push_beat(16'hAAAA, 1'b0);
    push_beat(16'h5555, 1'b0);

    // side 0 acts as 1: padding first, then one pixel and six flush beats
    set_side(11'h000);
    push_beat(16'h1234, 1'b1);
    push_beat(16'hFFFF, 1'b0);
    for (int k = 0; k < 6; k++) begin
      push_beat(16'($urandom), k[0]);
    end

    // side 3 all at full height: the center pixel clamps
    set_side(11'd3);
    for (int k = 0; k < 9; k++) begin
      push_beat(16'hFFFF, 1'b0);
    end
    for (int k = 0; k < 12; k++) begin
      push_beat(16'($urandom), k[0], k == 5);
    end

    cut_open = 1'b1;
    cfg = 11'd3;
    while (n_sent < RAND_ITEMS) begin
      if (cut_open || $urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 39);
        if (r == 0) begin
          cfg = 11'd0;
        end else if (r == 1) begin
          cfg = 11'($urandom_range(1025, 2047));
        end else if (r < 30) begin
          cfg = 11'($urandom_range(1, 8));
        end else begin
          cfg = 11'($urandom_range(9, 16));
        end
        set_side(cfg);
      end
      side = side_in_use(cfg);
      full = side * side + 3 * side + 3;
      if (side > 16) begin
        cut = $urandom_range(1, 12);
      end else if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, full - 1);
      end else begin
        cut = full;
      end
      // stop near the item budget
      if (cut > RAND_ITEMS - n_sent) begin
        cut = RAND_ITEMS - n_sent;
      end
      cut_open = (cut < full);
      queue_frame(side, cut);
    end

    settle();
    if (n_bad == 0 && blur_due.size() == 0) begin
      $display("gaussian_blur_7x7_unit verification clean");
    end else begin
      $display("gaussian_blur_7x7_unit verification failed");
    end
    $finish;
  end

endmodule
